// ===== rtl/icms_pkg.sv =====
// Shared types and constants for the inversion-count merge-sort block.
// Used by icms_seq, inversion_count_merge_sort_top and the testbench; no dependencies.
`default_nettype none

package icms_pkg;

	localparam int DEF_MAX_ITEMS  = 1024;
	localparam int DEF_VALUE_BITS = 32;
	localparam int IN_VALUE_WIDTH = 32;
	localparam int TOTAL_WIDTH    = 19;
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_READ,
		S_MERGE,
		S_DONE
	} icms_state_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic wr_en;
		logic wr_bank;
		logic rd_bank;
	} icms_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/inversion_count_merge_sort_top.sv =====
// Top level of the inversion-count merge-sort block: load logic, two ping-pong memory banks
// and the merge sequencer. Depends on icms_pkg, icms_ram and icms_seq.
//
// Values are loaded one per cycle while busy is low; the beat with last_item set starts the
// count and raises busy. In each merge pass every stored element is read, then compared and
// written, and each run opens with a setup step; a set of n values takes ceil(log2 n)
// passes, all through the single compare unit and the registered read ports of the banks.
// The result is shown for one cycle with done high and cannot be stalled by the receiver;
// busy falls in the following cycle.
`default_nettype none

module inversion_count_merge_sort_top
	import icms_pkg::*;
#(
	parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [IN_VALUE_WIDTH-1:0] value,
	input  wire logic                      last_item,
	output logic                           busy,
	output logic                           done,
	output logic      [TOTAL_WIDTH-1:0]    inversion_total,
	output logic                           overflowed
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int IW = $clog2(MAX_ITEMS + 1);

	icms_ctrl_t            ctrl;
	logic [IW-1:0]         count_q;
	logic                  ovf_q;
	logic                  accept, has_room, load_we;
	logic [VALUE_BITS-1:0] load_data;
	logic [IW-1:0]         n_go;
	logic                  go;

	logic [AW-1:0]         rd_addr_a, rd_addr_b, seq_waddr, bank0_waddr;
	logic [VALUE_BITS-1:0] seq_wdata, bank0_wdata;
	logic [VALUE_BITS-1:0] b0_rdata_a, b0_rdata_b, b1_rdata_a, b1_rdata_b;
	logic [VALUE_BITS-1:0] src_rdata_a, src_rdata_b;
	logic                  bank0_we, bank1_we;

	generate
		if (VALUE_BITS <= IN_VALUE_WIDTH) begin : g_trunc
			assign load_data = value[VALUE_BITS-1:0];
		end else begin : g_extend
			assign load_data = {{(VALUE_BITS - IN_VALUE_WIDTH){1'b0}}, value};
		end
	endgenerate

	assign accept   = start && !busy;
	assign has_room = count_q < IW'(MAX_ITEMS);
	assign load_we  = accept && has_room;
	assign go       = accept && last_item;
	assign n_go     = has_room ? (count_q + IW'(1)) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (last_item) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + IW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign bank0_we    = load_we || (ctrl.wr_en && !ctrl.wr_bank);
	assign bank1_we    = ctrl.wr_en && ctrl.wr_bank;
	assign bank0_waddr = ctrl.busy ? seq_waddr : count_q[AW-1:0];
	assign bank0_wdata = ctrl.busy ? seq_wdata : load_data;

	icms_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_BITS)
	) u_bank0 (
		.clk     (clk),
		.we      (bank0_we),
		.waddr   (bank0_waddr),
		.wdata   (bank0_wdata),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (b0_rdata_a),
		.rdata_b (b0_rdata_b)
	);

	icms_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_BITS)
	) u_bank1 (
		.clk     (clk),
		.we      (bank1_we),
		.waddr   (seq_waddr),
		.wdata   (seq_wdata),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (b1_rdata_a),
		.rdata_b (b1_rdata_b)
	);

	assign src_rdata_a = ctrl.rd_bank ? b1_rdata_a : b0_rdata_a;
	assign src_rdata_b = ctrl.rd_bank ? b1_rdata_b : b0_rdata_b;

	icms_seq #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.n_in      (n_go),
		.ovf_in    (ovf_q || !has_room),
		.rdata_a   (src_rdata_a),
		.rdata_b   (src_rdata_b),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (seq_waddr),
		.wr_data   (seq_wdata),
		.ctrl      (ctrl),
		.total     (inversion_total),
		.ovf       (overflowed)
	);

	assign busy = ctrl.busy;
	assign done = ctrl.done;

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe raised while the block is idle.");

	a_last_starts_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy)
		else $error("Final beat did not start the count.");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("Result strobe lasted more than one cycle.");

	a_no_merge_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> (busy && !done))
		else $error("Merge write issued outside a merge pass.");

endmodule

`default_nettype wire

// ===== rtl/icms_ram.sv =====
// Simple memory with one write port and two registered read ports.
// Depends on nothing; instantiated twice by the top level as ping-pong banks.
`default_nettype none

module icms_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/icms_seq.sv =====
// Merge-pass sequencer: walks the runs of a bottom-up merge sort, one compare per element,
// and accumulates the inversion count with a saturating adder. Depends on icms_pkg.
`default_nettype none

module icms_seq
	import icms_pkg::*;
#(
	parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	localparam int AW        = $clog2(MAX_ITEMS),
	localparam int IW        = $clog2(MAX_ITEMS + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   go,
	input  wire logic [IW-1:0]          n_in,
	input  wire logic                   ovf_in,
	input  wire logic [VALUE_BITS-1:0]  rdata_a,
	input  wire logic [VALUE_BITS-1:0]  rdata_b,
	output logic      [AW-1:0]          rd_addr_a,
	output logic      [AW-1:0]          rd_addr_b,
	output logic      [AW-1:0]          wr_addr,
	output logic      [VALUE_BITS-1:0]  wr_data,
	output icms_ctrl_t                  ctrl,
	output logic      [TOTAL_WIDTH-1:0] total,
	output logic                        ovf
);

	localparam int SW = ((IW > TOTAL_WIDTH) ? IW : TOTAL_WIDTH) + 1;

	icms_state_t state_q, state_d;

	logic [IW-1:0]          n_q, w_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic                   src_q, ovf_q;
	logic [TOTAL_WIDTH-1:0] acc_q;

	logic                   a_avail, b_avail, take_a, run_end, pass_end, all_done;
	logic [IW-1:0]          k_nxt, inc;
	logic [IW:0]            lo_w, w2;
	logic [IW+1:0]          lo_2w;
	logic [IW-1:0]          mid_new, hi_new;
	logic [SW-1:0]          sum;
	logic [TOTAL_WIDTH-1:0] acc_sat;

	always_comb begin
		a_avail  = a_q < mid_q;
		b_avail  = b_q < hi_q;
		take_a   = a_avail && (!b_avail || (rdata_a <= rdata_b));
		k_nxt    = k_q + IW'(1);
		run_end  = k_nxt == hi_q;
		pass_end = hi_q == n_q;
		w2       = {w_q, 1'b0};
		all_done = w2 >= {1'b0, n_q};
		lo_w     = {1'b0, lo_q} + {1'b0, w_q};
		lo_2w    = {2'b00, lo_q} + {1'b0, w_q, 1'b0};
		mid_new  = (lo_w > {1'b0, n_q}) ? n_q : lo_w[IW-1:0];
		hi_new   = (lo_2w > {2'b00, n_q}) ? n_q : lo_2w[IW-1:0];
		inc      = (!take_a && a_avail) ? (mid_q - a_q) : '0;
		sum      = SW'(acc_q) + SW'(inc);
		acc_sat  = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl.busy    = 1'b1;
		ctrl.done    = 1'b0;
		ctrl.wr_en   = 1'b0;
		ctrl.wr_bank = ~src_q;
		ctrl.rd_bank = src_q;
		unique case (state_q)
			S_IDLE: begin
				ctrl.busy = 1'b0;
				if (go) begin
					state_d = (n_in < IW'(2)) ? S_DONE : S_SETUP;
				end
			end
			S_SETUP: begin
				state_d = S_READ;
			end
			S_READ: begin
				state_d = S_MERGE;
			end
			S_MERGE: begin
				ctrl.wr_en = 1'b1;
				if (run_end && pass_end && all_done) begin
					state_d = S_DONE;
				end else if (run_end) begin
					state_d = S_SETUP;
				end else begin
					state_d = S_READ;
				end
			end
			S_DONE: begin
				ctrl.done = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			w_q   <= '0;
			lo_q  <= '0;
			mid_q <= '0;
			hi_q  <= '0;
			a_q   <= '0;
			b_q   <= '0;
			k_q   <= '0;
			src_q <= 1'b0;
			ovf_q <= 1'b0;
			acc_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						n_q   <= n_in;
						ovf_q <= ovf_in;
						w_q   <= IW'(1);
						lo_q  <= '0;
						src_q <= 1'b0;
						acc_q <= '0;
					end
				end
				S_SETUP: begin
					mid_q <= mid_new;
					hi_q  <= hi_new;
					a_q   <= lo_q;
					b_q   <= mid_new;
					k_q   <= lo_q;
				end
				S_MERGE: begin
					acc_q <= acc_sat;
					k_q   <= k_nxt;
					if (take_a) begin
						a_q <= a_q + IW'(1);
					end else begin
						b_q <= b_q + IW'(1);
					end
					if (run_end) begin
						if (pass_end) begin
							lo_q  <= '0;
							w_q   <= w2[IW-1:0];
							src_q <= ~src_q;
						end else begin
							lo_q <= hi_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_addr_a = a_q[AW-1:0];
	assign rd_addr_b = b_q[AW-1:0];
	assign wr_addr   = k_q[AW-1:0];
	assign wr_data   = take_a ? rdata_a : rdata_b;
	assign total     = acc_q;
	assign ovf       = ovf_q;

endmodule

`default_nettype wire

// ===== dv/inversion_count_merge_sort_top_test.sv =====
// Self-checking testbench for inversion_count_merge_sort_top: sends sets of values as start/busy
// beats and checks each count and overflow flag against an in-bench inversion counter.
// Depends on icms_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module inversion_count_merge_sort_top_test
	import icms_pkg::*;
;

	localparam int KEPT_BITS = (DEF_VALUE_BITS < IN_VALUE_WIDTH) ? DEF_VALUE_BITS : IN_VALUE_WIDTH;
	localparam logic [IN_VALUE_WIDTH-1:0] KEPT_MASK =
		{IN_VALUE_WIDTH{1'b1}} >> (IN_VALUE_WIDTH - KEPT_BITS);
	localparam int ITEM_TARGET = 1700;

	typedef enum int {
		FILL_RANDOM,
		FILL_FEW_LEVELS,
		FILL_RISING,
		FILL_FALLING,
		FILL_EXTREMES
	} fill_mode_t;

	typedef struct {
		logic [IN_VALUE_WIDTH-1:0] value;
		logic                      last_item;
		bit                        wait_for_drain;
	} beat_t;

	typedef struct {
		logic [TOTAL_WIDTH-1:0] total;
		logic                   overflowed;
	} tally_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic [IN_VALUE_WIDTH-1:0] value = '0;
	logic                      last_item = 1'b0;
	logic                      busy;
	logic                      done;
	logic [TOTAL_WIDTH-1:0]    inversion_total;
	logic                      overflowed;

	beat_t                     beat_q[$];
	tally_t                    tally_q[$];
	logic [IN_VALUE_WIDTH-1:0] set_values[$];
	bit                        set_dropped;
	bit                        beat_taken;
	int                        beats_sent;
	int                        beats_queued;
	int                        errors;

	inversion_count_merge_sort_top #(
		.MAX_ITEMS (DEF_MAX_ITEMS),
		.VALUE_BITS(DEF_VALUE_BITS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.value          (value),
		.last_item      (last_item),
		.busy           (busy),
		.done           (done),
		.inversion_total(inversion_total),
		.overflowed     (overflowed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [TOTAL_WIDTH-1:0] tally_inversions();
		longint pairs;
		pairs = 0;
		for (int i = 0; i < set_values.size(); i++)
			for (int j = i + 1; j < set_values.size(); j++)
				if (set_values[i] > set_values[j])
					pairs++;
		if (pairs > longint'(TOTAL_MAX))
			return TOTAL_MAX;
		return pairs[TOTAL_WIDTH-1:0];
	endfunction

	task automatic queue_beat(input logic [IN_VALUE_WIDTH-1:0] v, input logic last,
			input bit drain);
		beat_t b;
		b.value = v;
		b.last_item = last;
		b.wait_for_drain = drain;
		beat_q.push_back(b);
		beats_queued++;
	endtask

	task automatic queue_set(input int n, input fill_mode_t mode, input bit drain);
		logic [IN_VALUE_WIDTH-1:0] v;
		logic [IN_VALUE_WIDTH-1:0] step;
		v = $urandom;
		step = $urandom_range(1, 1000);
		for (int i = 0; i < n; i++) begin
			case (mode)
				FILL_FEW_LEVELS: v = $urandom_range(0, 3);
				FILL_RISING: v = (i == 0) ? v : v + step;
				FILL_FALLING: v = (i == 0) ? v : v - step;
				FILL_EXTREMES: v = $urandom_range(0, 1) ? '1 : '0;
				default: v = $urandom;
			endcase
			queue_beat(v, i == n - 1, drain && i == 0);
		end
	endtask

	always @(posedge clk) begin
		tally_t exp;
		if (arst_n) begin
			beat_taken <= start && !busy;
			if (done) begin
				if (tally_q.size() == 0) begin
					$display("%0t: result with nothing expected: total %0d overflowed %0b",
						$time, inversion_total, overflowed);
					errors++;
				end else begin
					exp = tally_q.pop_front();
					if (inversion_total !== exp.total) begin
						$display("%0t: inversion_total expected %0d actual %0d",
							$time, exp.total, inversion_total);
						errors++;
					end
					if (overflowed !== exp.overflowed) begin
						$display("%0t: overflowed expected %0b actual %0b",
							$time, exp.overflowed, overflowed);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (set_values.size() < DEF_MAX_ITEMS)
					set_values.push_back(value & KEPT_MASK);
				else
					set_dropped = 1'b1;
				if (last_item) begin
					exp.total = tally_inversions();
					exp.overflowed = set_dropped;
					tally_q.push_back(exp);
					set_values.delete();
					set_dropped = 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		beat_t nxt;
		bit quiet;
		if (arst_n && (!start || beat_taken)) begin
			quiet = beats_sent >= 300 && beats_sent < 1400;
			if (beat_q.size() == 0 || (beat_q[0].wait_for_drain && tally_q.size() != 0) ||
					(!quiet && $urandom_range(0, 99) < 36)) begin
				start <= 1'b0;
				value <= $urandom;
				last_item <= $urandom_range(0, 1);
			end else begin
				nxt = beat_q.pop_front();
				start <= 1'b1;
				value <= nxt.value;
				last_item <= nxt.last_item;
				beats_sent++;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int n;
		// Short sets at the edges of the value range, then a descending run and a few shapes.
		queue_beat('0, 1'b1, 1'b0);
		queue_beat('1, 1'b1, 1'b0);
		queue_beat('1, 1'b0, 1'b0);
		queue_beat('0, 1'b1, 1'b0);
		queue_beat(32'd5, 1'b0, 1'b0);
		queue_beat(32'd5, 1'b1, 1'b0);
		queue_beat('0, 1'b0, 1'b0);
		queue_beat('1, 1'b1, 1'b0);
		for (int i = 4; i >= 0; i--)
			queue_beat(i, i == 0, i == 4);
		queue_set(4, FILL_RISING, 1'b0);
		queue_set(6, FILL_FEW_LEVELS, 1'b0);
		while (beats_queued < ITEM_TARGET) begin
			if (beats_queued >= 400 && beats_queued < 470) begin
				// A full store in strict descending order gives the largest count; the
				// trailing beats, the last one included, find no room.
				for (int i = DEF_MAX_ITEMS - 1; i >= 0; i--)
					queue_beat(i, 1'b0, i == DEF_MAX_ITEMS - 1);
				queue_beat($urandom, 1'b0, 1'b0);
				queue_beat($urandom, 1'b0, 1'b0);
				queue_beat($urandom, 1'b1, 1'b0);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
			queue_set(n, fill_mode_t'($urandom_range(0, 4)), $urandom_range(0, 19) == 0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beat_q.size() != 0 || start || tally_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
